// ===== rtl/sasp_pkg.sv =====
package sasp_pkg;

  // Field widths
  localparam int WIND_W      = 14;
  localparam int SPEED_W     = 16;
  localparam int ANGLE_W     = 12;
  localparam int CFG_ANGLE_W = 8;
  localparam int GAIN_W      = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  // Datapath widths
  localparam int DVD_W  = 40;
  localparam int DVS_W  = 16;
  localparam int OPND_W = 33;
  localparam int PROD_W = 66;
  localparam int FACT_W = 50;
  localparam int ERR_W  = 17;
  localparam int PREV_W = 24;
  localparam int DOT_W  = 26;
  localparam int INTG_W = 32;
  localparam int INC_W  = 24;
  localparam int COS_W  = 31;

  localparam int COS_TABLE_BITS_DEF = 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ANGLE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_TARGET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_P_GAIN       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_I_GAIN       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_D_GAIN       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_PERIOD  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_LAW    = 3'd7;

  // Datapath operations
  typedef logic [4:0] op_t;
  localparam op_t OP_NONE    = 5'd0;
  localparam op_t OP_LOAD    = 5'd1;
  localparam op_t OP_DIV_I   = 5'd2;
  localparam op_t OP_MUL_U   = 5'd3;
  localparam op_t OP_TAKE_W  = 5'd4;
  localparam op_t OP_MUL_R   = 5'd5;
  localparam op_t OP_TAKE_R  = 5'd6;
  localparam op_t OP_MUL_C   = 5'd7;
  localparam op_t OP_TAKE_C  = 5'd8;
  localparam op_t OP_DIV_L   = 5'd9;
  localparam op_t OP_TAKE_L  = 5'd10;
  localparam op_t OP_DIV_D   = 5'd11;
  localparam op_t OP_TAKE_D  = 5'd12;
  localparam op_t OP_MUL_INC = 5'd13;
  localparam op_t OP_MUL_P   = 5'd14;
  localparam op_t OP_DIV_P   = 5'd15;
  localparam op_t OP_MUL_D   = 5'd16;
  localparam op_t OP_MUL_I   = 5'd17;
  localparam op_t OP_TAKE_I  = 5'd18;
  localparam op_t OP_UPD     = 5'd19;
  localparam op_t OP_FINAL   = 5'd20;
  localparam op_t OP_ZERO    = 5'd21;

  typedef struct packed {
    op_t        op;
    logic [2:0] step;
  } cmd_t;

  typedef struct packed {
    logic in_ok;
    logic law;
    logic div_busy;
    logic e_pos;
    logic out_free;
  } sts_t;

  // Cosine polynomial, Q30
  localparam logic [COS_W-1:0] ONE_Q30 = 31'd1073741824;
  localparam logic [COS_W-1:0] CA1 = 31'd1324675880;
  localparam logic [COS_W-1:0] CA2 = 31'd272375583;
  localparam logic [COS_W-1:0] CA3 = 31'd22401993;
  localparam logic [COS_W-1:0] CA4 = 31'd987048;
  localparam logic [COS_W-1:0] CA5 = 31'd27060;
  localparam logic [2:0] COS_LAST_STEP = 3'd4;

  function automatic logic [COS_W-1:0] cos_coef(input logic [2:0] step);
    logic [COS_W-1:0] c;
    case (step)
      3'd0:    c = CA4;
      3'd1:    c = CA3;
      3'd2:    c = CA2;
      default: c = CA1;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/sasp_div.sv =====
module sasp_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [sasp_pkg::DVD_W-1:0]   dividend_i,
  input  logic [sasp_pkg::DVS_W-1:0]   divisor_i,
  output logic                         busy_o,
  output logic [sasp_pkg::DVD_W-1:0]   quotient_o
);
  import sasp_pkg::*;

  localparam int CntW = $clog2(DVD_W + 1);

  logic             busy_q, busy_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [DVS_W:0]   trial, diff;

  // One quotient bit per cycle, restoring
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    trial  = {rem_q, quo_q[DVD_W-1]};
    diff   = trial - {1'b0, dvs_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DVD_W);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (!diff[DVS_W]) begin
        rem_d = diff[DVS_W-1:0];
        quo_d = {quo_q[DVD_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DVS_W-1:0];
        quo_d = {quo_q[DVD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider started while busy");
`endif

endmodule

// ===== rtl/sasp_ctrl.sv =====
module sasp_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  sasp_pkg::sts_t  sts_i,
  output sasp_pkg::cmd_t  cmd_o
);
  import sasp_pkg::*;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DIV_I   = 5'd1;
  localparam logic [4:0] S_MUL_U   = 5'd3;
  localparam logic [4:0] S_TAKE_W  = 5'd4;
  localparam logic [4:0] S_MUL_R   = 5'd5;
  localparam logic [4:0] S_TAKE_R  = 5'd6;
  localparam logic [4:0] S_MUL_C   = 5'd7;
  localparam logic [4:0] S_TAKE_C  = 5'd8;
  localparam logic [4:0] S_DIV_L   = 5'd9;
  localparam logic [4:0] S_TAKE_L  = 5'd11;
  localparam logic [4:0] S_DIV_D   = 5'd12;
  localparam logic [4:0] S_WAIT_D  = 5'd13;
  localparam logic [4:0] S_TAKE_D  = 5'd14;
  localparam logic [4:0] S_MUL_INC = 5'd15;
  localparam logic [4:0] S_MUL_P   = 5'd16;
  localparam logic [4:0] S_DIV_P   = 5'd17;
  localparam logic [4:0] S_WAIT_P  = 5'd18;
  localparam logic [4:0] S_MUL_D   = 5'd19;
  localparam logic [4:0] S_MUL_I   = 5'd20;
  localparam logic [4:0] S_TAKE_I  = 5'd21;
  localparam logic [4:0] S_UPD     = 5'd22;
  localparam logic [4:0] S_FINAL   = 5'd23;
  localparam logic [4:0] S_ZERO    = 5'd24;

  logic [4:0] state_q, state_d;
  logic [2:0] step_q, step_d;

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o.op   = OP_NONE;
    cmd_o.step = step_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          if (sts_i.in_ok) begin
            state_d = sts_i.law ? S_DIV_L : S_DIV_I;
          end
        end
      end
      S_DIV_I: begin
        cmd_o.op = OP_DIV_I;
        state_d  = S_MUL_U;
      end
      S_MUL_U: begin
        cmd_o.op = OP_MUL_U;
        state_d  = S_TAKE_W;
      end
      S_TAKE_W: begin
        cmd_o.op = OP_TAKE_W;
        step_d   = '0;
        state_d  = S_MUL_R;
      end
      S_MUL_R: begin
        cmd_o.op = OP_MUL_R;
        state_d  = S_TAKE_R;
      end
      S_TAKE_R: begin
        cmd_o.op = OP_TAKE_R;
        if (step_q == COS_LAST_STEP) begin
          state_d = S_MUL_C;
        end else begin
          step_d  = step_q + 1'b1;
          state_d = S_MUL_R;
        end
      end
      S_MUL_C: begin
        cmd_o.op = OP_MUL_C;
        state_d  = S_TAKE_C;
      end
      S_TAKE_C: begin
        cmd_o.op = OP_TAKE_C;
        state_d  = S_DIV_D;
      end
      S_DIV_L: begin
        cmd_o.op = OP_DIV_L;
        state_d  = S_TAKE_L;
      end
      S_TAKE_L: begin
        cmd_o.op = OP_TAKE_L;
        state_d  = S_DIV_D;
      end
      S_DIV_D: begin
        cmd_o.op = OP_DIV_D;
        state_d  = S_WAIT_D;
      end
      S_WAIT_D: begin
        if (!sts_i.div_busy) state_d = S_TAKE_D;
      end
      S_TAKE_D: begin
        cmd_o.op = OP_TAKE_D;
        state_d  = sts_i.e_pos ? S_MUL_INC : S_ZERO;
      end
      S_MUL_INC: begin
        cmd_o.op = OP_MUL_INC;
        state_d  = S_MUL_P;
      end
      S_MUL_P: begin
        cmd_o.op = OP_MUL_P;
        state_d  = S_DIV_P;
      end
      S_DIV_P: begin
        cmd_o.op = OP_DIV_P;
        state_d  = S_WAIT_P;
      end
      S_WAIT_P: begin
        if (!sts_i.div_busy) state_d = S_MUL_D;
      end
      S_MUL_D: begin
        cmd_o.op = OP_MUL_D;
        state_d  = S_MUL_I;
      end
      S_MUL_I: begin
        cmd_o.op = OP_MUL_I;
        state_d  = S_TAKE_I;
      end
      S_TAKE_I: begin
        cmd_o.op = OP_TAKE_I;
        state_d  = S_UPD;
      end
      S_UPD: begin
        cmd_o.op = OP_UPD;
        state_d  = S_FINAL;
      end
      S_FINAL: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_FINAL;
          state_d  = S_IDLE;
        end
      end
      S_ZERO: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_ZERO;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

`ifndef SYNTHESIS
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_TAKE_R |-> step_q <= COS_LAST_STEP) else $error("cosine step overrun");
  a_drop_missing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i && !sts_i.in_ok) |=> state_q == S_IDLE)
    else $error("missing-data transaction left idle");
`endif

endmodule

// ===== rtl/sasp_dp.sv =====
module sasp_dp #(
  parameter int CosTableBits = sasp_pkg::COS_TABLE_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  sasp_pkg::cmd_t                        cmd_i,
  output sasp_pkg::sts_t                        sts_o,
  input  logic                                  cfg_we_i,
  input  logic [sasp_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [sasp_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic signed [sasp_pkg::WIND_W-1:0]    wind_dir_i,
  input  logic                                  wind_known_i,
  input  logic [sasp_pkg::SPEED_W-1:0]          speed_i,
  input  logic                                  speed_known_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [sasp_pkg::ANGLE_W-1:0]          sail_angle_o,
  output logic                                  clipped_o
);
  import sasp_pkg::*;

  localparam int KW = CosTableBits + 1;
  localparam logic [KW-1:0] N_K = {1'b1, {CosTableBits{1'b0}}};
  localparam logic signed [WIND_W:0] TURN_S   = 15'sd5760;
  localparam logic signed [WIND_W:0] TURN2_S  = 15'sd11520;
  // ceil(2^32 / 45): exact floor(x / 45) for x below 2^18
  localparam logic [OPND_W-1:0] RECIP_45 = 33'd95443718;

  // Configuration
  logic [CFG_ANGLE_W-1:0] max_q, min_q;
  logic [GAIN_W-1:0]      target_q, pg_q, ig_q, dg_q, period_q;
  logic                   law_q;

  // Working registers
  logic signed [WIND_W-1:0] dir_q;
  logic [SPEED_W-1:0]       speed_q;
  logic [COS_W-1:0]         w_q, r_q;
  logic [ANGLE_W-1:0]       base_q;
  logic signed [DOT_W-1:0]  dot_q;
  logic [INC_W-1:0]         inc_q;
  logic signed [FACT_W-1:0] factor_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PREV_W-1:0] prev_q;
  logic signed [INTG_W-1:0] integral_q;
  logic                     out_valid_q;
  logic [ANGLE_W-1:0]       angle_q;
  logic                     clip_q;

  logic signed [WIND_W:0]   dir_x, p_x;
  logic [12:0]              phase;
  logic [1:0]               quad;
  logic [10:0]              rem_w;
  logic [11:0]              a_w;
  logic [19:0]              lin_lo, lin_hi, lin_num;
  logic [23:0]              idx_num;
  logic [GAIN_W-1:0]        target_eff, period_eff;
  logic signed [ERR_W-1:0]  e_w;
  logic signed [ERR_W:0]    diff_w;
  logic [ERR_W:0]           diff_mag;
  logic [KW-1:0]            i_w, k_w;
  logic [COS_W-1:0]         u_w, cp_w, shr_w;
  logic [OPND_W-1:0]        one_minus;
  logic [41:0]              csum;
  logic [ANGLE_W-1:0]       cbase, hi_w, lo_w;
  logic [DOT_W-1:0]         qmag;
  logic [INTG_W:0]          isum;
  logic                     fac_in, load_out, mul_en;

  logic                     div_start, div_busy;
  logic [DVD_W-1:0]         div_dvd, div_quo;
  logic [DVS_W-1:0]         div_dvs;
  logic signed [OPND_W-1:0] opa, opb;

  // Phase folding into one turn, quadrant and remainder
  always_comb begin
    dir_x = {dir_q[WIND_W-1], dir_q};
    if (dir_x < -TURN_S)       p_x = dir_x + TURN2_S;
    else if (dir_x < 0)        p_x = dir_x + TURN_S;
    else if (dir_x >= TURN_S)  p_x = dir_x - TURN_S;
    else                       p_x = dir_x;
    phase = p_x[12:0];
    if (phase >= 13'd4320) begin
      quad  = 2'd3;
      rem_w = 11'(phase - 13'd4320);
    end else if (phase >= 13'd2880) begin
      quad  = 2'd2;
      rem_w = 11'(phase - 13'd2880);
    end else if (phase >= 13'd1440) begin
      quad  = 2'd1;
      rem_w = 11'(phase - 13'd1440);
    end else begin
      quad  = 2'd0;
      rem_w = phase[10:0];
    end
    a_w = (phase >= 13'd2880) ? 12'(13'd5760 - phase) : phase[11:0];
  end

  assign lin_lo     = min_q * (12'd2880 - a_w);
  assign lin_hi     = max_q * a_w;
  // Divide by 180 as (x / 4) / 45, by 1440 as (x / 32) / 45
  assign lin_num    = lin_lo + lin_hi + 20'd90;
  assign idx_num    = (24'(rem_w) << CosTableBits) + 24'd720;
  assign target_eff = (target_q == '0) ? GAIN_W'(1) : target_q;
  assign period_eff = (period_q == '0) ? GAIN_W'(1) : period_q;
  assign e_w        = $signed({1'b0, target_q}) - $signed({1'b0, speed_q});
  assign diff_w     = ERR_W'(0) + {e_w[ERR_W-1], e_w} - prev_q[ERR_W:0];
  assign diff_mag   = diff_w[ERR_W] ? (~diff_w + 1'b1) : diff_w;

  // Cosine point index, mirrored in odd quadrants
  assign i_w   = prod_q[32+KW-1:32];
  assign k_w   = quad[0] ? (N_K - i_w) : i_w;
  assign u_w   = COS_W'(k_w) << (30 - CosTableBits);
  assign shr_w = prod_q[60:30];
  assign cp_w  = (r_q >= ONE_Q30) ? '0 : (ONE_Q30 - r_q);
  assign one_minus = (quad[0] ^ quad[1]) ? (OPND_W'(ONE_Q30) + OPND_W'(cp_w))
                                         : (OPND_W'(ONE_Q30) - OPND_W'(cp_w));
  assign csum  = prod_q[41:0] + 42'h0_2000_0000;
  assign cbase = csum[41:30];
  assign hi_w  = {max_q, 4'b0000};
  assign lo_w  = {min_q, 4'b0000};
  assign qmag  = {1'b0, div_quo[DOT_W-2:0]};
  assign isum  = {integral_q[INTG_W-1], integral_q} + (INTG_W + 1)'(inc_q);
  assign fac_in = !factor_q[FACT_W-1] && (factor_q[FACT_W-1:16] == '0)
                  && (factor_q[15:0] != '0);
  assign load_out = (cmd_i.op == OP_FINAL) || (cmd_i.op == OP_ZERO);

  // Divider operand select
  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = DVS_W'(1);
    case (cmd_i.op)
      OP_DIV_D: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'(diff_mag) << 8;
        div_dvs   = period_eff;
      end
      OP_DIV_P: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'(prod_q[31:0]) << 8;
        div_dvs   = target_eff;
      end
      default: ;
    endcase
  end

  sasp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  // Shared multiplier operand select
  always_comb begin
    mul_en = 1'b1;
    opa    = '0;
    opb    = '0;
    case (cmd_i.op)
      OP_DIV_I: begin
        opa = OPND_W'(idx_num[23:5]);
        opb = RECIP_45;
      end
      OP_DIV_L: begin
        opa = OPND_W'(lin_num[19:2]);
        opb = RECIP_45;
      end
      OP_MUL_U: begin
        opa = OPND_W'(u_w);
        opb = OPND_W'(u_w);
      end
      OP_MUL_R: begin
        opa = OPND_W'(r_q);
        opb = OPND_W'(w_q);
      end
      OP_MUL_C: begin
        opa = one_minus;
        opb = OPND_W'(720);
      end
      OP_MUL_INC: begin
        opa = OPND_W'(e_w);
        opb = OPND_W'(period_eff);
      end
      OP_MUL_P: begin
        opa = OPND_W'(pg_q);
        opb = OPND_W'(e_w);
      end
      OP_MUL_D: begin
        opa = OPND_W'(dg_q);
        opb = OPND_W'(dot_q);
      end
      OP_MUL_I: begin
        opa = OPND_W'(ig_q);
        opb = OPND_W'(integral_q);
      end
      OP_UPD: begin
        opa = OPND_W'(base_q);
        opb = OPND_W'(factor_q[27:0]);
      end
      default: mul_en = 1'b0;
    endcase
  end

  // Configuration, state and output control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q       <= 8'd90;
      min_q       <= 8'd10;
      target_q    <= 16'd256;
      pg_q        <= 16'd1280;
      ig_q        <= 16'd128;
      dg_q        <= 16'd256;
      period_q    <= 16'd128;
      law_q       <= 1'b0;
      prev_q      <= '0;
      integral_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_MAX_ANGLE:    max_q    <= cfg_data_i[CFG_ANGLE_W-1:0];
          REG_MIN_ANGLE:    min_q    <= cfg_data_i[CFG_ANGLE_W-1:0];
          REG_SPEED_TARGET: target_q <= cfg_data_i;
          REG_P_GAIN:       pg_q     <= cfg_data_i;
          REG_I_GAIN:       ig_q     <= cfg_data_i;
          REG_D_GAIN:       dg_q     <= cfg_data_i;
          REG_LOOP_PERIOD:  period_q <= cfg_data_i;
          REG_ANGLE_LAW:    law_q    <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (cmd_i.op == OP_TAKE_D) begin
        prev_q <= PREV_W'(e_w);
      end
      if (cmd_i.op == OP_UPD && fac_in) begin
        integral_q <= (!isum[INTG_W] && isum[INTG_W-1]) ? {1'b0, {(INTG_W-1){1'b1}}}
                                                        : isum[INTG_W-1:0];
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q <= opa * opb;
    end
    case (cmd_i.op)
      OP_LOAD: begin
        dir_q   <= wind_dir_i;
        speed_q <= speed_i;
      end
      OP_TAKE_W: begin
        w_q <= shr_w;
        r_q <= CA5;
      end
      OP_TAKE_R: begin
        r_q <= (cmd_i.step == COS_LAST_STEP) ? shr_w : (cos_coef(cmd_i.step) - shr_w);
      end
      OP_TAKE_C: begin
        if (cbase > hi_w)      base_q <= hi_w;
        else if (cbase < lo_w) base_q <= lo_w;
        else                   base_q <= cbase;
      end
      OP_TAKE_L: base_q <= prod_q[32+ANGLE_W-1:32];
      OP_TAKE_D: dot_q  <= diff_w[ERR_W] ? -$signed(qmag) : $signed(qmag);
      OP_MUL_P:  inc_q  <= prod_q[INC_W+7:8];
      OP_MUL_D:  factor_q <= FACT_W'(div_quo);
      OP_MUL_I:  factor_q <= factor_q + prod_q[FACT_W-1:0];
      OP_TAKE_I: factor_q <= factor_q + prod_q[FACT_W-1:0];
      OP_FINAL: begin
        if (base_q == '0) begin
          angle_q <= '0;
          clip_q  <= 1'b0;
        end else if (factor_q[FACT_W-1]) begin
          angle_q <= '0;
          clip_q  <= 1'b1;
        end else if ((factor_q[FACT_W-2:28] != '0) || (prod_q[39:28] != '0)) begin
          angle_q <= '1;
          clip_q  <= 1'b1;
        end else begin
          angle_q <= prod_q[27:16];
          clip_q  <= 1'b0;
        end
      end
      OP_ZERO: begin
        angle_q <= '0;
        clip_q  <= 1'b0;
      end
      default: ;
    endcase
  end

  assign sts_o.in_ok    = wind_known_i & speed_known_i;
  assign sts_o.law      = law_q;
  assign sts_o.div_busy = div_busy;
  assign sts_o.e_pos    = !e_w[ERR_W-1] && (e_w != '0);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign sail_angle_o = angle_q;
  assign clipped_o    = clip_q;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && out_valid_q) |-> !out_stall_i) else $error("result overwritten");
  a_integral_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(integral_q) |-> (integral_q > $past(integral_q)))
    else $error("integral moved down");
`endif

endmodule

// ===== rtl/sail_angle_speed_pid.sv =====
// Channel  Handshake                  Payload
// cfg      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
// in       in_valid_i / in_stall_o    wind_dir_i, wind_known_i, speed_i, speed_known_i
// out      out_valid_o / out_stall_i  sail_angle_o, clipped_o
//
// One transaction at a time. The input stalls after an accept until the transaction
// is done, longer with the cosine law than with the linear law; the two serial divisions
// by loop period and speed target set most of that. When speed is at or above target
// the tick ends early and the result is a zero angle.
// A transaction with a missing flag is dropped in its accept cycle.
// Reset restores register defaults and clears the PID history; no clearing pass.
// A result waits in the output register; the next transaction is taken meanwhile
// and only its own result stalls on a full output register.
module sail_angle_speed_pid #(
  parameter int CosTableBits = sasp_pkg::COS_TABLE_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [sasp_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [sasp_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [sasp_pkg::WIND_W-1:0]    wind_dir_i,
  input  logic                                  wind_known_i,
  input  logic [sasp_pkg::SPEED_W-1:0]          speed_i,
  input  logic                                  speed_known_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [sasp_pkg::ANGLE_W-1:0]          sail_angle_o,
  output logic                                  clipped_o
);
  import sasp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Registers are always writable; writes land only while idle by contract
  assign cfg_ready_o = 1'b1;

  // Sequencer: steps the datapath through cosine, law, and PID phases
  sasp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: config registers, shared multiplier, serial divider, PID state
  sasp_dp #(
    .CosTableBits (CosTableBits)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_valid_i & cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .wind_dir_i    (wind_dir_i),
    .wind_known_i  (wind_known_i),
    .speed_i       (speed_i),
    .speed_known_i (speed_known_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sail_angle_o  (sail_angle_o),
    .clipped_o     (clipped_o)
  );

endmodule
